### rtl/ugng_pkg.sv
// Package for the uniform grid neighbour gather block: constants, codes, types and helpers.
`timescale 1ns / 1ps

package ugng_pkg;

   localparam int MAX_COLS       = 32;
   localparam int MAX_ROWS       = 32;
   localparam int CELL_CAPACITY  = 16;
   localparam int MAX_NEIGHBOURS = 64;

   localparam int GRID_CELLS  = (MAX_COLS + 2) * (MAX_ROWS + 2);
   localparam int ENTRY_DEPTH = GRID_CELLS * CELL_CAPACITY;

   localparam int CELL_ADDR_W  = $clog2(GRID_CELLS);
   localparam int ENTRY_ADDR_W = $clog2(ENTRY_DEPTH);
   localparam int COUNT_W      = $clog2(CELL_CAPACITY + 1);
   localparam int NCOUNT_W     = $clog2(MAX_NEIGHBOURS + 1);
   localparam int COORD_W      = 6;

   localparam int ID_W    = 16;
   localparam int POS_W   = 24;
   localparam int HALF_W  = 23;
   localparam int SCALE_W = 20;
   localparam int NMAX_W  = 7;

   localparam int MUL_A_W = POS_W + 1;
   localparam int MUL_B_W = SCALE_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int FRAC_W  = 24;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_GRID_COLS    = 3'd0;
   localparam logic [2:0] REG_GRID_ROWS    = 3'd1;
   localparam logic [2:0] REG_HALF_WORLD_X = 3'd2;
   localparam logic [2:0] REG_HALF_WORLD_Y = 3'd3;
   localparam logic [2:0] REG_SCALE_X      = 3'd4;
   localparam logic [2:0] REG_SCALE_Y      = 3'd5;
   localparam logic [2:0] REG_NEIGHBOURS   = 3'd6;

   typedef struct packed {
      logic [COORD_W-1:0] cols;
      logic [COORD_W-1:0] rows;
      logic [HALF_W-1:0]  half_x;
      logic [HALF_W-1:0]  half_y;
      logic [SCALE_W-1:0] scale_x;
      logic [SCALE_W-1:0] scale_y;
      logic [NMAX_W-1:0]  nmax;
   } cfg_type;

   typedef struct packed {
      logic                    cnt_we;
      logic [CELL_ADDR_W-1:0]  cnt_waddr;
      logic [COUNT_W-1:0]      cnt_wdata;
      logic [CELL_ADDR_W-1:0]  cnt_raddr;
      logic                    ent_we;
      logic [ENTRY_ADDR_W-1:0] ent_waddr;
      logic [ID_W-1:0]         ent_wdata;
      logic [ENTRY_ADDR_W-1:0] ent_raddr;
   } store_cmd_type;

   // Turns a scaled product into an interior coordinate; bit COORD_W is the saturation flag.
   function automatic logic [COORD_W:0] axis_cell(logic signed [MUL_P_W-1:0] p,
                                                  logic [COORD_W-1:0] lim);
      logic               sat;
      logic [COORD_W-1:0] c;
      if (p[MUL_P_W-1]) begin
         c   = COORD_W'(1);
         sat = !((&p[MUL_P_W-1:FRAC_W]) && (|p[FRAC_W-1:0]));
      end else if (p[MUL_P_W-1:FRAC_W] >= (MUL_P_W-FRAC_W)'(lim)) begin
         c   = lim;
         sat = 1'b1;
      end else begin
         c   = p[FRAC_W+COORD_W-1:FRAC_W] + COORD_W'(1);
         sat = 1'b0;
      end
      return {sat, c};
   endfunction

endpackage

### rtl/ugng_if.sv
// Request and response channel interfaces of the grid neighbour gather block.
`timescale 1ns / 1ps

interface ugng_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic [ugng_pkg::ID_W-1:0]           entity_id;
   logic signed [ugng_pkg::POS_W-1:0]   pos_x;
   logic signed [ugng_pkg::POS_W-1:0]   pos_y;

   modport source (output valid, operation, entity_id, pos_x, pos_y, input ready);
   modport sink (input valid, operation, entity_id, pos_x, pos_y, output ready);
endinterface

interface ugng_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ugng_pkg::ID_W-1:0] neighbour_id;
   logic                      has_neighbour;
   logic [1:0]                status;
   logic                      last;

   modport source (output valid, neighbour_id, has_neighbour, status, last, input ready);
   modport sink (input valid, neighbour_id, has_neighbour, status, last, output ready);
endinterface

### rtl/ugng_csr.sv
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps

module ugng_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ugng_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ugng_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ugng_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output ugng_pkg::cfg_type                   cfg
);

   logic [ugng_pkg::COORD_W-1:0] cols_ff, rows_ff;
   logic [ugng_pkg::HALF_W-1:0]  half_x_ff, half_y_ff;
   logic [ugng_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [ugng_pkg::NMAX_W-1:0]  nmax_ff;
   logic [2:0]                   reg_index;
   logic                         wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff    <= ugng_pkg::COORD_W'(32);
         rows_ff    <= ugng_pkg::COORD_W'(32);
         half_x_ff  <= '0;
         half_y_ff  <= '0;
         scale_x_ff <= '0;
         scale_y_ff <= '0;
         nmax_ff    <= ugng_pkg::NMAX_W'(16);
      end else if (wr_en) begin
         case (reg_index)
            ugng_pkg::REG_GRID_COLS:    cols_ff    <= csr_pwdata[ugng_pkg::COORD_W-1:0];
            ugng_pkg::REG_GRID_ROWS:    rows_ff    <= csr_pwdata[ugng_pkg::COORD_W-1:0];
            ugng_pkg::REG_HALF_WORLD_X: half_x_ff  <= csr_pwdata[ugng_pkg::HALF_W-1:0];
            ugng_pkg::REG_HALF_WORLD_Y: half_y_ff  <= csr_pwdata[ugng_pkg::HALF_W-1:0];
            ugng_pkg::REG_SCALE_X:      scale_x_ff <= csr_pwdata[ugng_pkg::SCALE_W-1:0];
            ugng_pkg::REG_SCALE_Y:      scale_y_ff <= csr_pwdata[ugng_pkg::SCALE_W-1:0];
            ugng_pkg::REG_NEIGHBOURS:   nmax_ff    <= csr_pwdata[ugng_pkg::NMAX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ugng_pkg::REG_GRID_COLS:    csr_prdata = ugng_pkg::CSR_DATA_W'(cols_ff);
         ugng_pkg::REG_GRID_ROWS:    csr_prdata = ugng_pkg::CSR_DATA_W'(rows_ff);
         ugng_pkg::REG_HALF_WORLD_X: csr_prdata = ugng_pkg::CSR_DATA_W'(half_x_ff);
         ugng_pkg::REG_HALF_WORLD_Y: csr_prdata = ugng_pkg::CSR_DATA_W'(half_y_ff);
         ugng_pkg::REG_SCALE_X:      csr_prdata = ugng_pkg::CSR_DATA_W'(scale_x_ff);
         ugng_pkg::REG_SCALE_Y:      csr_prdata = ugng_pkg::CSR_DATA_W'(scale_y_ff);
         ugng_pkg::REG_NEIGHBOURS:   csr_prdata = ugng_pkg::CSR_DATA_W'(nmax_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Out-of-range sizes and limits are pulled into their legal ranges here.
   always_comb begin
      cfg.cols = (cols_ff == '0) ? ugng_pkg::COORD_W'(1) :
                 (cols_ff > ugng_pkg::COORD_W'(ugng_pkg::MAX_COLS)) ?
                 ugng_pkg::COORD_W'(ugng_pkg::MAX_COLS) : cols_ff;
      cfg.rows = (rows_ff == '0) ? ugng_pkg::COORD_W'(1) :
                 (rows_ff > ugng_pkg::COORD_W'(ugng_pkg::MAX_ROWS)) ?
                 ugng_pkg::COORD_W'(ugng_pkg::MAX_ROWS) : rows_ff;
      cfg.nmax = (nmax_ff == '0) ? ugng_pkg::NMAX_W'(1) :
                 (nmax_ff > ugng_pkg::NMAX_W'(ugng_pkg::MAX_NEIGHBOURS)) ?
                 ugng_pkg::NMAX_W'(ugng_pkg::MAX_NEIGHBOURS) : nmax_ff;
      cfg.half_x  = half_x_ff;
      cfg.half_y  = half_y_ff;
      cfg.scale_x = scale_x_ff;
      cfg.scale_y = scale_y_ff;
   end

endmodule

### rtl/ugng_mul.sv
// Shared registered signed multiplier used for both axis scalings and the cell index.
`timescale 1ns / 1ps

module ugng_mul (
   input  logic                                      clock,
   input  logic signed [ugng_pkg::MUL_A_W-1:0]       mul_a,
   input  logic signed [ugng_pkg::MUL_B_W-1:0]       mul_b,
   output logic signed [ugng_pkg::MUL_P_W-1:0]       mul_p
);

   logic signed [ugng_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [ugng_pkg::MUL_P_W-1:0] prod_in;

   always_comb prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

### rtl/ugng_store.sv
// Cell count memory and cell entry memory, each with one write and one registered read port.
`timescale 1ns / 1ps

module ugng_store (
   input  logic                                 clock,
   input  ugng_pkg::store_cmd_type              cmd,
   output logic [ugng_pkg::COUNT_W-1:0]         cnt_q,
   output logic [ugng_pkg::ID_W-1:0]            ent_q
);

   logic [ugng_pkg::COUNT_W-1:0] cnt_mem [ugng_pkg::GRID_CELLS];
   logic [ugng_pkg::ID_W-1:0]    ent_mem [ugng_pkg::ENTRY_DEPTH];
   logic [ugng_pkg::COUNT_W-1:0] cnt_q_ff;
   logic [ugng_pkg::ID_W-1:0]    ent_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.cnt_we) begin
         cnt_mem[cmd.cnt_waddr] <= cmd.cnt_wdata;
      end
      cnt_q_ff <= cnt_mem[cmd.cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ent_we) begin
         ent_mem[cmd.ent_waddr] <= cmd.ent_wdata;
      end
      ent_q_ff <= ent_mem[cmd.ent_raddr];
   end

   assign cnt_q = cnt_q_ff;
   assign ent_q = ent_q_ff;

endmodule

### rtl/uniform_grid_neighbour_gather_core.sv
// Top level of the uniform grid neighbour gather engine: sequencer, output register, glue.
`timescale 1ns / 1ps

// The block bins entity ids into a grid of up to 32 by 32 interior cells, framed by a border
// ring, and answers neighbour queries over the 3x3 block of cells around a position. It works
// on one request at a time and is not ready while a request is in progress; a finished result
// waits in an output register, so the next request can be taken while it is still unread. All
// three position-to-cell multiplications share one registered multiplier, and every cell count
// and every stored id passes through one read port of its memory, which sets the timing.
// A query walk stops once the neighbour limit is met, and the response side can stall it.
// A clear sweeps the count memory one cell per cycle. After reset the same sweep runs once
// before the first request is accepted; configuration writes are taken at any time.
// Configuration should be written only while the block is idle.

module uniform_grid_neighbour_gather_core (
   input  logic                                clock,
   input  logic                                reset,
   ugng_req_if.sink                            req_chan,
   ugng_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ugng_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ugng_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ugng_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CA_W = ugng_pkg::CELL_ADDR_W;
   localparam int EA_W = ugng_pkg::ENTRY_ADDR_W;
   localparam int CN_W = ugng_pkg::COUNT_W;
   localparam int NC_W = ugng_pkg::NCOUNT_W;
   localparam int CO_W = ugng_pkg::COORD_W;

   // Sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CLR     = 4'd1;
   localparam logic [3:0] ST_MULX    = 4'd2;
   localparam logic [3:0] ST_CHKX    = 4'd3;
   localparam logic [3:0] ST_CHKY    = 4'd4;
   localparam logic [3:0] ST_MULI    = 4'd5;
   localparam logic [3:0] ST_IDX     = 4'd6;
   localparam logic [3:0] ST_INS_RD  = 4'd7;
   localparam logic [3:0] ST_INS_CHK = 4'd8;
   localparam logic [3:0] ST_Q_CELL  = 4'd9;
   localparam logic [3:0] ST_Q_CNT   = 4'd10;
   localparam logic [3:0] ST_Q_ENT   = 4'd11;
   localparam logic [3:0] ST_Q_EVAL  = 4'd12;
   localparam logic [3:0] ST_Q_NEXT  = 4'd13;
   localparam logic [3:0] ST_FINISH  = 4'd14;

   ugng_pkg::cfg_type       cfg;
   ugng_pkg::store_cmd_type cmd;

   logic [CN_W-1:0]                      cnt_q;
   logic [ugng_pkg::ID_W-1:0]            ent_q;
   logic signed [ugng_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [ugng_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [ugng_pkg::MUL_P_W-1:0]  mul_p;
   logic [CO_W:0]                        axis_x, axis_y;
   logic [CO_W-1:0]                      stride;

   // Control state
   logic [3:0]      state_ff, state_in;
   logic [CA_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic            clr_resp_ff, clr_resp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            pend_valid_ff, pend_valid_in;
   logic [NC_W-1:0] n_ff, n_in;

   // Working registers
   logic [1:0]                op_ff, op_in;
   logic [ugng_pkg::ID_W-1:0] id_ff, id_in;
   logic signed [ugng_pkg::POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [CO_W-1:0]           x_ff, x_in, y_ff, y_in;
   logic                      sat_ff, sat_in;
   logic [CA_W-1:0]           idx_ff, idx_in;
   logic [CA_W-1:0]           cell_addr_ff, cell_addr_in;
   logic [1:0]                row_ff, row_in, col_ff, col_in;
   logic [CN_W-1:0]           cnt_ff, cnt_in, k_ff, k_in;
   logic [1:0]                stat_ff, stat_in;
   logic [ugng_pkg::ID_W-1:0] pend_id_ff, pend_id_in;

   // Output register payload
   logic [ugng_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                      rsp_has_ff, rsp_has_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic out_free;
   logic req_fire;

   ugng_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ugng_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ugng_store u_store (
      .clock (clock),
      .cmd   (cmd),
      .cnt_q (cnt_q),
      .ent_q (ent_q)
   );

   assign stride   = cfg.cols + CO_W'(2);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign axis_x   = ugng_pkg::axis_cell(mul_p, cfg.cols);
   assign axis_y   = ugng_pkg::axis_cell(mul_p, cfg.rows);

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.neighbour_id  = rsp_id_ff;
   assign rsp_chan.has_neighbour = rsp_has_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.last          = rsp_last_ff;

   // The shared multiplier: x scaling, then y scaling, then row times stride for the index.
   always_comb begin
      case (state_ff)
         ST_MULX: begin
            mul_a = $signed({pos_x_ff[ugng_pkg::POS_W-1], pos_x_ff})
                  + $signed({2'b00, cfg.half_x});
            mul_b = $signed({1'b0, cfg.scale_x});
         end
         ST_CHKX: begin
            mul_a = $signed({pos_y_ff[ugng_pkg::POS_W-1], pos_y_ff})
                  + $signed({2'b00, cfg.half_y});
            mul_b = $signed({1'b0, cfg.scale_y});
         end
         ST_MULI: begin
            mul_a = $signed(ugng_pkg::MUL_A_W'(y_ff));
            mul_b = $signed(ugng_pkg::MUL_B_W'(stride));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Memory commands. The count read address follows the insert cell or the walking cell,
   // and the entry read address always follows the current walk position, so a stalled
   // evaluation keeps seeing the same entry.
   always_comb begin
      cmd.cnt_raddr = (state_ff == ST_INS_RD || state_ff == ST_INS_CHK) ? idx_ff : cell_addr_ff;
      cmd.ent_raddr = EA_W'(cell_addr_ff) * EA_W'(ugng_pkg::CELL_CAPACITY) + EA_W'(k_ff);
      cmd.cnt_we    = 1'b0;
      cmd.cnt_waddr = idx_ff;
      cmd.cnt_wdata = cnt_q + CN_W'(1);
      cmd.ent_we    = 1'b0;
      cmd.ent_waddr = EA_W'(idx_ff) * EA_W'(ugng_pkg::CELL_CAPACITY) + EA_W'(cnt_q);
      cmd.ent_wdata = id_ff;
      if (state_ff == ST_CLR) begin
         cmd.cnt_we    = 1'b1;
         cmd.cnt_waddr = clr_cnt_ff;
         cmd.cnt_wdata = '0;
      end else if (state_ff == ST_INS_CHK &&
                   cnt_q < CN_W'(ugng_pkg::CELL_CAPACITY)) begin
         cmd.cnt_we = 1'b1;
         cmd.ent_we = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_resp_in   = clr_resp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      pend_valid_in = pend_valid_ff;
      n_in          = n_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      sat_in        = sat_ff;
      idx_in        = idx_ff;
      cell_addr_in  = cell_addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      stat_in       = stat_ff;
      pend_id_in    = pend_id_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_chan.operation;
               id_in         = req_chan.entity_id;
               pos_x_in      = req_chan.pos_x;
               pos_y_in      = req_chan.pos_y;
               pend_valid_in = 1'b0;
               n_in          = '0;
               stat_in       = ugng_pkg::STATUS_OK;
               case (req_chan.operation)
                  ugng_pkg::OP_CLEAR: begin
                     state_in    = ST_CLR;
                     clr_cnt_in  = '0;
                     clr_resp_in = 1'b1;
                  end
                  ugng_pkg::OP_INSERT, ugng_pkg::OP_QUERY: state_in = ST_MULX;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR: begin
            clr_cnt_in = clr_cnt_ff + CA_W'(1);
            if (clr_cnt_ff == CA_W'(ugng_pkg::GRID_CELLS - 1)) begin
               state_in = clr_resp_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_MULX: state_in = ST_CHKX;
         ST_CHKX: begin
            x_in     = axis_x[CO_W-1:0];
            sat_in   = axis_x[CO_W];
            state_in = ST_CHKY;
         end
         ST_CHKY: begin
            y_in     = axis_y[CO_W-1:0];
            sat_in   = sat_ff || axis_y[CO_W];
            state_in = ST_MULI;
         end
         ST_MULI: state_in = ST_IDX;
         ST_IDX: begin
            idx_in = mul_p[CA_W-1:0] + CA_W'(x_ff);
            if (op_ff == ugng_pkg::OP_INSERT) begin
               state_in = ST_INS_RD;
            end else begin
               // Top-left cell of the 3x3 block; always inside the framed grid.
               cell_addr_in = mul_p[CA_W-1:0] + CA_W'(x_ff) - CA_W'(stride) - CA_W'(1);
               row_in       = '0;
               col_in       = '0;
               stat_in      = sat_ff ? ugng_pkg::STATUS_SAT : ugng_pkg::STATUS_OK;
               state_in     = ST_Q_CELL;
            end
         end
         ST_INS_RD: state_in = ST_INS_CHK;
         ST_INS_CHK: begin
            if (cnt_q >= CN_W'(ugng_pkg::CELL_CAPACITY)) begin
               stat_in = ugng_pkg::STATUS_FULL;
            end else begin
               stat_in = sat_ff ? ugng_pkg::STATUS_SAT : ugng_pkg::STATUS_OK;
            end
            state_in = ST_FINISH;
         end
         ST_Q_CELL: state_in = ST_Q_CNT;
         ST_Q_CNT: begin
            cnt_in   = cnt_q;
            k_in     = '0;
            state_in = (cnt_q == '0) ? ST_Q_NEXT : ST_Q_ENT;
         end
         ST_Q_ENT: state_in = ST_Q_EVAL;
         ST_Q_EVAL: begin
            if (ent_q == id_ff) begin
               // The querying entity never counts as its own neighbour.
               if (k_ff + CN_W'(1) < cnt_ff) begin
                  k_in     = k_ff + CN_W'(1);
                  state_in = ST_Q_ENT;
               end else begin
                  state_in = ST_Q_NEXT;
               end
            end else if (!pend_valid_ff || out_free) begin
               // The previous find is released with last clear; the newest one is held
               // back until the walk knows whether another follows.
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = pend_id_ff;
                  rsp_has_in    = 1'b1;
                  rsp_status_in = stat_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = ent_q;
               n_in          = n_ff + NC_W'(1);
               if (n_ff + NC_W'(1) == NC_W'(cfg.nmax)) begin
                  state_in = ST_FINISH;
               end else if (k_ff + CN_W'(1) < cnt_ff) begin
                  k_in     = k_ff + CN_W'(1);
                  state_in = ST_Q_ENT;
               end else begin
                  state_in = ST_Q_NEXT;
               end
            end
         end
         ST_Q_NEXT: begin
            if (row_ff == 2'd2 && col_ff == 2'd2) begin
               state_in = ST_FINISH;
            end else if (col_ff == 2'd2) begin
               col_in       = '0;
               row_in       = row_ff + 2'd1;
               cell_addr_in = cell_addr_ff + CA_W'(stride) - CA_W'(2);
               state_in     = ST_Q_CELL;
            end else begin
               col_in       = col_ff + 2'd1;
               cell_addr_in = cell_addr_ff + CA_W'(1);
               state_in     = ST_Q_CELL;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = pend_valid_ff ? pend_id_ff : '0;
               rsp_has_in    = pend_valid_ff;
               rsp_status_in = stat_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         clr_cnt_ff    <= '0;
         clr_resp_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_resp_ff   <= clr_resp_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         n_ff          <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      sat_ff        <= sat_in;
      idx_ff        <= idx_in;
      cell_addr_ff  <= cell_addr_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      stat_ff       <= stat_in;
      pend_id_ff    <= pend_id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // While a request is in progress, the neighbours gathered never pass the configured limit.
   // In idle the count still holds the last query's total and the limit may have been rewritten.
   a_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (n_ff <= NC_W'(cfg.nmax)))
      else $error("neighbour count passed the limit");

   // An id is only appended to a cell that still has room.
   a_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ent_we |-> (cnt_q < CN_W'(ugng_pkg::CELL_CAPACITY)))
      else $error("entry written into a full cell");

   // Finishing a request always presents a final response on the next cycle.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("finished request without a final response");

   // No request is taken while the count memory is being swept.
   a_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |=> !$past(req_fire))
      else $error("request accepted during the clearing sweep");

endmodule
